// ----- design/ctb_pkg.sv -----
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared types and constants for the countdown timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package ctb_pkg;

	localparam int NUM_TIMERS    = 8;
	localparam int IDX_W         = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int REM_W         = 26;
	localparam int SECS_W        = 16;
	localparam int ELAPSED_W     = 16;
	localparam int OUT_IDX_W     = 3;
	localparam int ADDR_W        = 3;
	localparam int MS_PER_SECOND = 1000;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_SET      = 2'd1,
		OP_KILL     = 2'd2,
		OP_KILL_ALL = 2'd3
	} op_t;

	typedef struct packed {
		logic                 valid;
		op_t                  op;
		logic [REM_W-1:0]     load_ms;
		logic [ELAPSED_W-1:0] elapsed_ms;
	} cmd_t;

	typedef struct packed {
		logic             valid;
		logic             found;
		logic [IDX_W-1:0] idx;
		logic [REM_W-1:0] rem;
		logic             a_en;
		logic             a_exp;
	} tok_t;

endpackage

`default_nettype wire

// ----- design/ctb_if.sv -----
// ----------------------------------------------------------------------------
// ctb_if
// Valid/ready channels carrying request and result items of the timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctb_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    operation;
	logic [ctb_pkg::ADDR_W-1:0]    timer_index;
	logic [ctb_pkg::SECS_W-1:0]    set_seconds;
	logic [ctb_pkg::ELAPSED_W-1:0] elapsed_ms;

	modport source (output valid, operation, timer_index, set_seconds, elapsed_ms,
		input ready);
	modport sink (input valid, operation, timer_index, set_seconds, elapsed_ms,
		output ready);
endinterface

interface ctb_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          next_found;
	logic [ctb_pkg::OUT_IDX_W-1:0] next_index;
	logic [ctb_pkg::REM_W-1:0]     next_remaining_ms;
	logic                          addressed_enabled;
	logic                          addressed_expired;

	modport source (output valid, next_found, next_index, next_remaining_ms,
		addressed_enabled, addressed_expired, input ready);
	modport sink (input valid, next_found, next_index, next_remaining_ms,
		addressed_enabled, addressed_expired, output ready);
endinterface

`default_nettype wire

// ----- design/ctb_cell.sv -----
// ----------------------------------------------------------------------------
// ctb_cell
// One timer: holds enable and remaining time, applies the broadcast command
// and folds its own entry into the search token passing down the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire ctb_pkg::cmd_t             cmd,
	input  wire logic                      hit,
	input  wire logic [ctb_pkg::IDX_W-1:0] pos,
	input  wire ctb_pkg::tok_t             tok_in,
	output ctb_pkg::tok_t                  tok_out
);
	import ctb_pkg::*;

	logic             en_q;
	logic [REM_W-1:0] rem_q;
	logic             hit_q;
	tok_t             tok_q;
	tok_t             tok_d;
	logic [REM_W-1:0] elapsed_ext;

	assign elapsed_ext = REM_W'(cmd.elapsed_ms);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= 1'b0;
			rem_q <= '0;
			hit_q <= 1'b0;
		end else if (cmd.valid) begin
			hit_q <= hit;
			case (cmd.op)
				OP_TICK: begin
					if (en_q) begin
						rem_q <= (rem_q > elapsed_ext) ? (rem_q - elapsed_ext) : '0;
					end
				end
				OP_SET: begin
					if (hit) begin
						en_q  <= 1'b1;
						rem_q <= cmd.load_ms;
					end
				end
				OP_KILL: begin
					if (hit) begin
						en_q <= 1'b0;
					end
				end
				default: begin
					en_q <= 1'b0;
				end
			endcase
		end
	end

	// fold: strict less keeps the lower index on ties
	always_comb begin
		tok_d = tok_in;
		if (en_q && (!tok_in.found || (rem_q < tok_in.rem))) begin
			tok_d.found = 1'b1;
			tok_d.idx   = pos;
			tok_d.rem   = rem_q;
		end
		if (hit_q) begin
			tok_d.a_en  = en_q;
			tok_d.a_exp = en_q && (rem_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

// ----- design/countdown_timer_bank.sv -----
// ----------------------------------------------------------------------------
// countdown_timer_bank
// Bank of countdown timers with tick, set, kill and kill-all operations.
// ----------------------------------------------------------------------------
// Each timer lives in one cell of a chain. An accepted item updates every cell
// at the accepting edge; a search token then walks the chain one cell per
// cycle, picking the enabled timer with the least remaining time (lowest index
// on ties) and the addressed timer's flags. Each cell registers the token, and
// the result is registered into rsp once the token leaves the last cell. One
// item is handled at a time: req.ready rises again once the result has been
// taken.
// ----------------------------------------------------------------------------
`default_nettype none

module countdown_timer_bank (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ctb_req_if.sink    req,
	ctb_rsp_if.source  rsp
);
	import ctb_pkg::*;

	logic                  busy_q;
	logic                  start_q;
	logic                  req_fire;
	logic                  rsp_fire;
	cmd_t                  cmd;
	logic [NUM_TIMERS-1:0] hit;
	logic [NUM_TIMERS-1:0] tok_valid;
	tok_t                  chain [NUM_TIMERS+1];

	assign req_fire  = req.valid && req.ready;
	assign rsp_fire  = rsp.valid && rsp.ready;
	assign req.ready = !busy_q;

	assign cmd.valid      = req_fire;
	assign cmd.op         = op_t'(req.operation);
	assign cmd.load_ms    = REM_W'(32'(req.set_seconds) * 32'(MS_PER_SECOND));
	assign cmd.elapsed_ms = req.elapsed_ms;

	always_comb begin
		chain[0]       = '0;
		chain[0].valid = start_q;
	end

	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		assign hit[i]       = (32'(req.timer_index) == 32'(i));
		assign tok_valid[i] = chain[i+1].valid;

		ctb_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.hit     (hit[i]),
			.pos     (IDX_W'(i)),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			start_q   <= 1'b0;
			rsp.valid <= 1'b0;
		end else begin
			start_q <= req_fire;
			if (req_fire) begin
				busy_q <= 1'b1;
			end else if (rsp_fire) begin
				busy_q <= 1'b0;
			end
			if (chain[NUM_TIMERS].valid) begin
				rsp.valid <= 1'b1;
			end else if (rsp_fire) begin
				rsp.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chain[NUM_TIMERS].valid) begin
			rsp.next_found        <= chain[NUM_TIMERS].found;
			rsp.next_index        <= OUT_IDX_W'(chain[NUM_TIMERS].idx);
			rsp.next_remaining_ms <= chain[NUM_TIMERS].rem;
			rsp.addressed_enabled <= chain[NUM_TIMERS].a_en;
			rsp.addressed_expired <= chain[NUM_TIMERS].a_exp;
		end
	end

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tok_valid, start_q, rsp.valid}))
		else $error("more than one item in flight");

	a_hold_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("request accepted while a result is pending");

	a_start_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> start_q)
		else $error("search not launched after accepted item");

	a_busy_covers_work: assert property (@(posedge clk) disable iff (!arst_n)
		(start_q || (|tok_valid)) |-> busy_q)
		else $error("search running while bank reports idle");
`endif

endmodule

`default_nettype wire

// ----- bench/timer_bank_checker.sv -----
// ----------------------------------------------------------------------------
// timer_bank_checker
// Watches both channels of the countdown timer bank, keeps its own copy of the
// enable flags and remaining times, works out the expected result of every
// accepted request and compares each result item field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_bank_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	ctb_req_if        req,
	ctb_rsp_if        rsp,
	output int        fail_count,
	output int        awaited,
	output int        compared
);
	import ctb_pkg::*;

	typedef struct packed {
		logic                 found;
		logic [OUT_IDX_W-1:0] idx;
		logic [REM_W-1:0]     rem;
		logic                 a_en;
		logic                 a_exp;
	} bank_status_t;

	bit               armed   [NUM_TIMERS];
	bit [REM_W-1:0]   left_ms [NUM_TIMERS];
	bank_status_t     status_due [$];
	bank_status_t     want;
	int               fails;
	int               compared_n;
	int               k;

	// apply one request to the bank, then rank the armed timers
	function automatic bank_status_t advance_bank(op_t op, logic [ADDR_W-1:0] sel,
			logic [SECS_W-1:0] secs, logic [ELAPSED_W-1:0] elapsed);
		bank_status_t s;
		bit           idx_ok;
		bit [REM_W-1:0] step_ms;
		int unsigned  load_ms;
		int           best;
		int           j;
		s = '0;
		idx_ok = int'(sel) < NUM_TIMERS;
		step_ms = REM_W'(elapsed);
		load_ms = 32'(secs);
		load_ms = load_ms * MS_PER_SECOND;
		case (op)
			OP_TICK: begin
				for (j = 0; j < NUM_TIMERS; j++)
					if (armed[j])
						left_ms[j] = (left_ms[j] > step_ms) ? left_ms[j] - step_ms : '0;
			end
			OP_SET: begin
				if (idx_ok) begin
					armed[sel] = 1'b1;
					left_ms[sel] = load_ms[REM_W-1:0];
				end
			end
			OP_KILL: begin
				if (idx_ok)
					armed[sel] = 1'b0;
			end
			default: begin
				for (j = 0; j < NUM_TIMERS; j++)
					armed[j] = 1'b0;
			end
		endcase
		// strict compare keeps the lowest index on ties, so the first expired timer wins
		best = -1;
		for (j = 0; j < NUM_TIMERS; j++)
			if (armed[j] && (best < 0 || left_ms[j] < left_ms[best]))
				best = j;
		if (best >= 0) begin
			s.found = 1'b1;
			s.idx = best[OUT_IDX_W-1:0];
			s.rem = left_ms[best];
		end
		if (idx_ok) begin
			s.a_en = armed[sel];
			s.a_exp = armed[sel] && (left_ms[sel] == '0);
		end
		return s;
	endfunction

	task automatic check_field(string field, longint unsigned exp_v, longint unsigned got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", field, exp_v, got_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (k = 0; k < NUM_TIMERS; k++) begin
				armed[k] = 1'b0;
				left_ms[k] = '0;
			end
			status_due.delete();
			fails = 0;
			compared_n = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (status_due.size() == 0) begin
					$error("result item arrived with no request outstanding");
					fails++;
				end else begin
					want = status_due.pop_front();
					check_field("next_found", 64'(want.found), 64'(rsp.next_found));
					check_field("next_index", 64'(want.idx), 64'(rsp.next_index));
					check_field("next_remaining_ms", 64'(want.rem),
						64'(rsp.next_remaining_ms));
					check_field("addressed_enabled", 64'(want.a_en),
						64'(rsp.addressed_enabled));
					check_field("addressed_expired", 64'(want.a_exp),
						64'(rsp.addressed_expired));
					compared_n++;
				end
			end
			if (req.valid && req.ready)
				status_due.push_back(advance_bank(op_t'(req.operation), req.timer_index,
					req.set_seconds, req.elapsed_ms));
		end
		fail_count <= fails;
		compared <= compared_n;
		awaited <= status_due.size();
	end

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the countdown timer bank: a directed walk through
// empty-bank, expiry, tie, re-arm and kill-all cases, then random requests
// with random gaps on both channels. Checking is done by timer_bank_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import ctb_pkg::*;

	localparam int RANDOM_ITEMS = 880;
	localparam int QUIET_LIMIT  = 400;

	logic clk = 1'b0;
	logic arst_n;

	ctb_req_if req ();
	ctb_rsp_if rsp ();

	int fail_count;
	int awaited;
	int compared;
	int quiet_cycles = 0;
	int sent_count   = 0;
	int op_count [4] = '{0, 0, 0, 0};
	int tx_calm      = 0;
	int rx_calm      = 0;

	countdown_timer_bank dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	timer_bank_checker watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.awaited    (awaited),
		.compared   (compared)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mostly uneven gaps, with the odd stretch of back-to-back items
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 19);
	endfunction

	task automatic send_item(input op_t op, input logic [ADDR_W-1:0] sel,
			input logic [SECS_W-1:0] secs, input logic [ELAPSED_W-1:0] elapsed);
		int gap;
		gap = draw_gap(tx_calm);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.operation <= op;
		req.timer_index <= sel;
		req.set_seconds <= secs;
		req.elapsed_ms <= elapsed;
		req.valid <= 1'b1;
		do @(posedge clk); while (!(req.valid && req.ready));
		sent_count++;
		op_count[int'(op)]++;
	endtask

	// hold the request side until every result is back
	task automatic drain_results();
		req.valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : result_side
		int gap;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap(rx_calm);
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				if ($urandom_range(0, 1) == 1)
					do @(posedge clk); while (!rsp.valid);
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!(rsp.valid && rsp.ready));
		end
	end

	initial begin : request_side
		int   n;
		int   pick;
		op_t  op;
		logic [SECS_W-1:0]    secs;
		logic [ELAPSED_W-1:0] elapsed;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.operation <= OP_TICK;
		req.timer_index <= '0;
		req.set_seconds <= '0;
		req.elapsed_ms <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_item(OP_TICK,     3'd0, 16'hFFFF, 16'hFFFF);
		send_item(OP_KILL,     3'd7, 16'h0000, 16'h0000);
		send_item(OP_KILL_ALL, 3'd5, 16'h0000, 16'h0000);
		send_item(OP_SET,      3'd0, 16'h0000, 16'h0000);
		send_item(OP_SET,      3'd7, 16'hFFFF, 16'h0000);
		send_item(OP_SET,      3'd3, 16'h0001, 16'h0000);
		send_item(OP_TICK,     3'd3, 16'h0000, 16'h0000);
		send_item(OP_TICK,     3'd3, 16'h0000, 16'd999);
		send_item(OP_KILL,     3'd0, 16'h0000, 16'h0000);
		send_item(OP_TICK,     3'd3, 16'h0000, 16'h0001);
		send_item(OP_SET,      3'd5, 16'h0001, 16'h0000);
		send_item(OP_KILL,     3'd3, 16'h0000, 16'h0000);
		send_item(OP_KILL,     3'd5, 16'h0000, 16'h0000);
		send_item(OP_SET,      3'd2, 16'hFFFF, 16'h0000);
		send_item(OP_SET,      3'd4, 16'hFFFF, 16'h0000);
		send_item(OP_SET,      3'd7, 16'h0001, 16'h0000);
		send_item(OP_TICK,     3'd7, 16'h5555, 16'hFFFF);
		send_item(OP_SET,      3'd6, 16'h5555, 16'hAAAA);
		send_item(OP_SET,      3'd1, 16'hAAAA, 16'h5555);
		send_item(OP_TICK,     3'd1, 16'h0000, 16'hAAAA);
		send_item(OP_KILL_ALL, 3'd7, 16'h0000, 16'h0000);
		send_item(OP_TICK,     3'd6, 16'h0000, 16'h5555);
		send_item(OP_SET,      3'd7, 16'h0002, 16'h0000);
		send_item(OP_KILL_ALL, 3'd2, 16'h0000, 16'h0000);
		drain_results();

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				op = OP_TICK;
			else if (pick < 75)
				op = OP_SET;
			else if (pick < 92)
				op = OP_KILL;
			else
				op = OP_KILL_ALL;
			// short loads so that ticks actually run timers down
			if ($urandom_range(0, 3) == 0)
				secs = 16'($urandom);
			else
				secs = 16'($urandom_range(0, 90));
			if ($urandom_range(0, 1) == 1)
				elapsed = 16'($urandom);
			else
				elapsed = 16'($urandom_range(0, 4000));
			send_item(op, 3'($urandom_range(0, 7)), secs, elapsed);
			if (n % 150 == 149)
				drain_results();
		end

		drain_results();
		repeat (NUM_TIMERS + 4) @(posedge clk);
		$display("%0d requests sent: %0d ticks, %0d sets, %0d kills, %0d kill-alls",
			sent_count, op_count[0], op_count[1], op_count[2], op_count[3]);
		$display("%0d result items compared against the predicted timer state", compared);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- countdown_timer_bank.f -----
design/ctb_pkg.sv
design/ctb_if.sv
design/ctb_cell.sv
design/countdown_timer_bank.sv
bench/timer_bank_checker.sv
bench/tb_top.sv
